>>> rtl/gfc_pkg.sv
// Shared types, constants and the segment decoder for the gated frequency counter.
// No dependencies; every other file uses it by scoped names.
package gfc_pkg;

  localparam int DIGITS_DEF   = 6;   // display digits
  localparam int COUNT_DIGITS = 6;   // decimal digits held by the count chain
  localparam int FREQ_W       = 20;
  localparam int GATE_W       = 24;
  localparam int SCAN_W       = 16;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_IDX_W    = 1;
  localparam int SEL_W        = 3;   // digit select, covers up to eight digits
  localparam int ENABLE_W     = 6;
  localparam int SEG_W        = 7;

  localparam logic [FREQ_W-1:0] COUNT_MAX  = 20'd999999;
  localparam logic [GATE_W-1:0] GATE_RESET = 24'd1000000;
  localparam logic [SCAN_W-1:0] SCAN_RESET = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_TICKS = 1'b0,
    REG_SCAN_TICKS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic rise;
    logic tick;
  } in_item_t;

  typedef struct packed {
    logic [ENABLE_W-1:0] digit_enable;
    logic [SEG_W-1:0]    segments;
    logic [FREQ_W-1:0]   frequency;
  } out_item_t;

  // Control that enters each decimal cell.
  typedef struct packed {
    logic step;      // an input beat is accepted this cycle
    logic carry;     // add one to this digit
    logic gate_end;  // latch and clear
  } cell_ctl_t;

  // Common-cathode pattern, bit 0 is segment a.
  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000110;
      4'd2:    s = 7'b1011011;
      4'd3:    s = 7'b1001111;
      4'd4:    s = 7'b1100110;
      4'd5:    s = 7'b1101101;
      4'd6:    s = 7'b1111101;
      4'd7:    s = 7'b0000111;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/gated_frequency_counter_7seg_unit.sv
// Top level of the gated frequency counter with a scanned seven-segment display.
// Depends on gfc_pkg, gfc_bcd_cell and gfc_out_skid.
//
//   channel  | ports                              | beat
//   ---------+------------------------------------+------------------------------
//   input    | in_valid, in_ready, in_data        | rise, tick
//   result   | out_valid, out_ready, out_data     | digit_enable, segments, frequency
//   config   | cfg_we, cfg_addr, cfg_wdata        | gate_ticks, scan_ticks
//
// One beat per cycle while in_ready is high; each yields one registered result beat.
// The count is held twice: a binary word for the frequency output and a row of
// decimal cells, one per digit, with the carry rippling cell to cell, so the
// shown digit is a plain select and no division is needed.
// Reset (synchronous, rst_n low) clears counts, timers, scan position and the
// output stage, and restores gate_ticks and scan_ticks to their defaults.
// A stalled result parks in a skid register; in_ready drops only while the skid is full.
module gated_frequency_counter_7seg_unit #(
  parameter int DIGITS = gfc_pkg::DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  gfc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gfc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [gfc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [gfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CD    = gfc_pkg::COUNT_DIGITS;

  // configuration registers
  logic [gfc_pkg::GATE_W-1:0] gate_ticks_r;
  logic [gfc_pkg::SCAN_W-1:0] scan_ticks_r;

  // measurement and scan state
  logic [gfc_pkg::FREQ_W-1:0] edge_count_r, edge_count_nxt;
  logic [gfc_pkg::FREQ_W-1:0] freq_r, freq_nxt;
  logic [gfc_pkg::GATE_W-1:0] gate_timer_r, gate_timer_nxt;
  logic [gfc_pkg::SCAN_W-1:0] scan_timer_r, scan_timer_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;

  logic                       step, inc, gate_end, scan_end;
  logic [gfc_pkg::FREQ_W-1:0] count_inc;
  logic [gfc_pkg::GATE_W:0]   gate_sum;
  logic [gfc_pkg::SCAN_W:0]   scan_sum;

  logic [CD:0]                carry;
  logic [3:0]                 lat_digit [CD];
  gfc_pkg::cell_ctl_t         cell_ctl [CD];

  logic [gfc_pkg::SEL_W-1:0]  sel;
  logic [7:0]                 enable_full;
  logic [3:0]                 shown;
  gfc_pkg::out_item_t         res;
  logic                       skid_ready;

  assign in_ready = skid_ready;
  assign step     = in_valid && in_ready;

  // Count first: saturate so the top digit never passes nine.
  assign inc       = in_data.rise && (edge_count_r != gfc_pkg::COUNT_MAX);
  assign count_inc = edge_count_r + gfc_pkg::FREQ_W'(inc);

  assign gate_sum = {1'b0, gate_timer_r} + 25'd1;
  assign scan_sum = {1'b0, scan_timer_r} + 17'd1;
  // shrunken or zero lengths end on the next tick
  assign gate_end = in_data.tick && (gate_sum >= {1'b0, gate_ticks_r});
  assign scan_end = in_data.tick && (scan_sum >= {1'b0, scan_ticks_r});

  always_comb begin
    edge_count_nxt = gate_end ? '0 : count_inc;
    freq_nxt       = gate_end ? count_inc : freq_r;

    if (gate_end) begin
      gate_timer_nxt = '0;
    end else if (in_data.tick) begin
      gate_timer_nxt = gate_sum[gfc_pkg::GATE_W-1:0];
    end else begin
      gate_timer_nxt = gate_timer_r;
    end

    if (scan_end) begin
      scan_timer_nxt = '0;
    end else if (in_data.tick) begin
      scan_timer_nxt = scan_sum[gfc_pkg::SCAN_W-1:0];
    end else begin
      scan_timer_nxt = scan_timer_r;
    end

    // advance the scan, wrap after the last digit
    if (!scan_end) begin
      pos_nxt = pos_r;
    end else if (pos_r >= POS_W'(DIGITS - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Row of decimal cells; cell 0 is units.
  assign carry[0] = inc;

  for (genvar i = 0; i < CD; i++) begin : g_cell
    assign cell_ctl[i] = '{step: step, carry: carry[i], gate_end: gate_end};

    gfc_bcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (cell_ctl[i]),
      .carry_o  (carry[i+1]),
      .lat_nxt_o(lat_digit[i])
    );
  end

  // Position 0 is the most significant digit; digits above the count read zero.
  always_comb begin
    sel         = gfc_pkg::SEL_W'(DIGITS - 1) - gfc_pkg::SEL_W'(pos_nxt);
    enable_full = 8'b1 << sel;
    shown       = (sel < gfc_pkg::SEL_W'(CD)) ? lat_digit[sel] : 4'd0;

    res.digit_enable = enable_full[gfc_pkg::ENABLE_W-1:0];
    res.segments     = gfc_pkg::seg_of(shown);
    res.frequency    = freq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_ticks_r <= gfc_pkg::GATE_RESET;
      scan_ticks_r <= gfc_pkg::SCAN_RESET;
      edge_count_r <= '0;
      freq_r       <= '0;
      gate_timer_r <= '0;
      scan_timer_r <= '0;
      pos_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (gfc_pkg::cfg_reg_t'(cfg_addr))
          gfc_pkg::REG_GATE_TICKS: gate_ticks_r <= cfg_wdata[gfc_pkg::GATE_W-1:0];
          gfc_pkg::REG_SCAN_TICKS: scan_ticks_r <= cfg_wdata[gfc_pkg::SCAN_W-1:0];
          default: ;
        endcase
      end
      // hold the measurement and scan state unless a beat is taken
      if (step) begin
        edge_count_r <= edge_count_nxt;
        freq_r       <= freq_nxt;
        gate_timer_r <= gate_timer_nxt;
        scan_timer_r <= scan_timer_nxt;
        pos_r        <= pos_nxt;
      end
    end
  end

  gfc_out_skid u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .s_valid(in_valid),
    .s_ready(skid_ready),
    .s_data (res),
    .m_valid(out_valid),
    .m_ready(out_ready),
    .m_data (out_data)
  );

endmodule

>>> rtl/gfc_bcd_cell.sv
// One decimal digit of the edge count with its latched copy.
// Depends on gfc_pkg; chained by the top level, carry passed up one cell per digit.
module gfc_bcd_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  gfc_pkg::cell_ctl_t ctl_i,
  output logic              carry_o,
  output logic [3:0]        lat_nxt_o
);

  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] lat_r, lat_nxt;
  logic [3:0] cnt_inc;

  always_comb begin
    carry_o = ctl_i.carry && (cnt_r == 4'd9);
    if (ctl_i.carry) begin
      cnt_inc = (cnt_r == 4'd9) ? 4'd0 : cnt_r + 4'd1;
    end else begin
      cnt_inc = cnt_r;
    end
    // the edge of this beat lands in the latched value
    cnt_nxt   = ctl_i.gate_end ? 4'd0 : cnt_inc;
    lat_nxt   = ctl_i.gate_end ? cnt_inc : lat_r;
    lat_nxt_o = lat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      lat_r <= 4'd0;
    end else if (ctl_i.step) begin
      cnt_r <= cnt_nxt;
      lat_r <= lat_nxt;
    end
  end

endmodule

>>> rtl/gfc_out_skid.sv
// Two-entry output stage: output register plus skid register.
// Depends on gfc_pkg for the result beat type.
module gfc_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  gfc_pkg::out_item_t s_data,
  output logic               m_valid,
  input  logic               m_ready,
  output gfc_pkg::out_item_t m_data
);

  logic               out_valid_r, skid_valid_r;
  gfc_pkg::out_item_t out_data_r, skid_data_r;
  logic               s_fire;

  assign s_ready = !skid_valid_r;
  assign s_fire  = s_valid && s_ready;
  assign m_valid = out_valid_r;
  assign m_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || m_ready) begin
      // output slot free: drain skid first, else take the new beat
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= s_fire;
        if (s_fire) begin
          out_data_r <= s_data;
        end
      end
    end else if (s_fire) begin
      // output stalled: park the beat
      skid_data_r  <= s_data;
      skid_valid_r <= 1'b1;
    end
  end

endmodule

>>> rtl/gfc_checker.sv
// Port-level checks for the gated frequency counter, bound to the top level.
// Depends on gfc_pkg and gated_frequency_counter_7seg_unit.
module gfc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input gfc_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input gfc_pkg::out_item_t             out_data,
  input logic                           cfg_we,
  input logic [gfc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input logic [gfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // a beat taken while the output is free shows up next cycle
  a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (!out_valid || out_ready)) |=> out_valid)
    else $error("accepted beat did not reach the output");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // the latched count never exceeds the saturation value
  a_freq_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.frequency <= gfc_pkg::COUNT_MAX))
    else $error("frequency above saturation");

endmodule

bind gated_frequency_counter_7seg_unit gfc_checker u_gfc_checker (.*);
